// ===== rtl/core/utf8_byte_stream_decoder_defines.svh =====
// Assertion macros for the UTF-8 byte stream decoder.
// Included by the top level; depends on nothing else.
`ifndef UTF8_BYTE_STREAM_DECODER_DEFINES_SVH
`define UTF8_BYTE_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8BSD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define U8BSD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/u8bsd_pkg.sv =====
// Shared types and constants for the UTF-8 byte stream decoder.
// No dependencies.
package u8bsd_pkg;

    localparam int unsigned CpWidth  = 31;
    localparam int unsigned RemWidth = 3;

    // Result status codes
    localparam logic [1:0] ST_CHAR  = 2'd0;
    localparam logic [1:0] ST_END   = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_TRUNC = 2'd3;

    // Lead byte class thresholds (inclusive upper bounds)
    localparam logic [7:0] LEAD_ASCII_MAX = 8'h7F;
    localparam logic [7:0] LEAD_2B_MAX    = 8'hDF;
    localparam logic [7:0] LEAD_3B_MAX    = 8'hEF;
    localparam logic [7:0] LEAD_4B_MAX    = 8'hF7;
    localparam logic [7:0] LEAD_5B_MAX    = 8'hFB;
    localparam logic [7:0] LEAD_6B_MAX    = 8'hFD;
    localparam logic [7:0] CONT_MIN       = 8'h80;

    // Outcome of decoding one transfer
    typedef struct packed {
        logic [RemWidth-1:0] remaining;
        logic [CpWidth-1:0]  acc;
        logic                emit;
        logic [CpWidth-1:0]  code_point;
        logic [1:0]          status;
    } step_t;

endpackage

// ===== rtl/core/u8bsd_step.sv =====
// Combinational decode of one byte or end mark against the current state.
// Depends on u8bsd_pkg.
module u8bsd_step (
    input  logic [u8bsd_pkg::RemWidth-1:0] remaining,
    input  logic [u8bsd_pkg::CpWidth-1:0]  acc,
    input  logic [7:0]                     data_byte,
    input  logic                           end_of_stream,
    output u8bsd_pkg::step_t               step
);

    logic [u8bsd_pkg::CpWidth-1:0] acc_shift;

    // Shift six payload bits into the accumulator; the top bits fall off
    assign acc_shift = {acc[u8bsd_pkg::CpWidth-7:0], data_byte[5:0]};

    always_comb begin
        step = '0;
        step.status = u8bsd_pkg::ST_CHAR;
        if (remaining == '0) begin
            // Idle: end mark, single byte, lead byte of a sequence, or invalid lead byte
            if (end_of_stream) begin
                step.emit   = 1'b1;
                step.status = u8bsd_pkg::ST_END;
            end else if (data_byte <= u8bsd_pkg::LEAD_ASCII_MAX) begin
                step.emit       = 1'b1;
                step.code_point = {{(u8bsd_pkg::CpWidth-8){1'b0}}, data_byte};
            end else if (data_byte <= u8bsd_pkg::LEAD_2B_MAX) begin
                step.acc       = {{(u8bsd_pkg::CpWidth-5){1'b0}}, data_byte[4:0]};
                step.remaining = u8bsd_pkg::RemWidth'(1);
            end else if (data_byte <= u8bsd_pkg::LEAD_3B_MAX) begin
                step.acc       = {{(u8bsd_pkg::CpWidth-4){1'b0}}, data_byte[3:0]};
                step.remaining = u8bsd_pkg::RemWidth'(2);
            end else if (data_byte <= u8bsd_pkg::LEAD_4B_MAX) begin
                step.acc       = {{(u8bsd_pkg::CpWidth-3){1'b0}}, data_byte[2:0]};
                step.remaining = u8bsd_pkg::RemWidth'(3);
            end else if (data_byte <= u8bsd_pkg::LEAD_5B_MAX) begin
                step.acc       = {{(u8bsd_pkg::CpWidth-2){1'b0}}, data_byte[1:0]};
                step.remaining = u8bsd_pkg::RemWidth'(4);
            end else if (data_byte <= u8bsd_pkg::LEAD_6B_MAX) begin
                step.acc       = {{(u8bsd_pkg::CpWidth-1){1'b0}}, data_byte[0]};
                step.remaining = u8bsd_pkg::RemWidth'(5);
            end else begin
                step.emit   = 1'b1;
                step.status = u8bsd_pkg::ST_BAD;
            end
        end else if (end_of_stream) begin
            // Sequence cut short
            step.emit   = 1'b1;
            step.status = u8bsd_pkg::ST_TRUNC;
        end else if (data_byte < u8bsd_pkg::CONT_MIN) begin
            // Not a continuation byte: drop it and go idle
            step.emit   = 1'b1;
            step.status = u8bsd_pkg::ST_BAD;
        end else if (remaining == u8bsd_pkg::RemWidth'(1)) begin
            // Last continuation byte: emit the code point
            step.emit       = 1'b1;
            step.code_point = acc_shift;
        end else begin
            step.acc       = acc_shift;
            step.remaining = remaining - u8bsd_pkg::RemWidth'(1);
        end
    end

endmodule

// ===== rtl/core/utf8_byte_stream_decoder.sv =====
// UTF-8 byte stream decoder (six-byte form), top level.
// Results are registered and reach the m_ channel in the cycle after the emitting transfer.
// Throughput: one byte per cycle, set by the single decode step between the
// state registers and the result register; s_ready drops only while a result waits.
// Reset (aresetn, synchronous, active low) returns the decoder to idle with
// an empty result register.
`include "utf8_byte_stream_decoder_defines.svh"

module utf8_byte_stream_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_data_byte,
    input  logic                          s_end_of_stream,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [u8bsd_pkg::CpWidth-1:0] m_code_point,
    output logic [1:0]                    m_status
);

    logic [u8bsd_pkg::RemWidth-1:0] bytes_remaining_reg;
    logic [u8bsd_pkg::CpWidth-1:0]  accumulator_reg;
    logic                           m_valid_reg;
    logic                           m_valid_next;
    logic [u8bsd_pkg::CpWidth-1:0]  m_code_point_reg;
    logic [1:0]                     m_status_reg;
    logic                           s_accept;
    u8bsd_pkg::step_t               step;

    // Take a new transfer unless a result is stalled
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    u8bsd_step u_step (
        .remaining     (bytes_remaining_reg),
        .acc           (accumulator_reg),
        .data_byte     (s_data_byte),
        .end_of_stream (s_end_of_stream),
        .step          (step)
    );

    // Result valid: load on an emitting transfer, clear when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_accept) begin
            m_valid_next = step.emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Advance decode state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_remaining_reg <= '0;
            accumulator_reg     <= '0;
            m_valid_reg         <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_accept) begin
                bytes_remaining_reg <= step.remaining;
                accumulator_reg     <= step.acc;
            end
        end
    end

    // Hold result payload until the next emitting transfer
    always_ff @(posedge aclk) begin
        if (s_accept && step.emit) begin
            m_code_point_reg <= step.code_point;
            m_status_reg     <= step.status;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_code_point = m_code_point_reg;
    assign m_status     = m_status_reg;

    // Checks on decoder state and results
    `U8BSD_ASSERT_NOW(a_rem_range, aclk, aresetn, 1'b1, bytes_remaining_reg <= u8bsd_pkg::RemWidth'(5), "continuation count out of range")
    `U8BSD_ASSERT_NOW(a_idle_acc_clear, aclk, aresetn, bytes_remaining_reg == '0, accumulator_reg == '0, "accumulator not cleared while idle")
    `U8BSD_ASSERT_NOW(a_status_cp_zero, aclk, aresetn, m_valid_reg && m_status_reg != u8bsd_pkg::ST_CHAR, m_code_point_reg == '0, "nonzero code point on a status result")
    `U8BSD_ASSERT_NEXT(a_idle_end, aclk, aresetn, s_accept && s_end_of_stream && bytes_remaining_reg == '0, m_valid_reg && m_status_reg == u8bsd_pkg::ST_END, "end mark while idle gave no end status")

endmodule

// ===== verif/utf8_byte_stream_decoder_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the UTF-8 byte stream decoder: watches both channels, predicts
// each decoded result and compares it with the m_ channel. Depends on u8bsd_pkg.
module utf8_byte_stream_decoder_checker
    import u8bsd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_end_of_stream,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [CpWidth-1:0] m_code_point,
    input  logic [1:0]         m_status,
    output int unsigned        mismatch_count,
    output int unsigned        pending_results,
    output int unsigned        results_checked,
    output int unsigned        status_results
);

    typedef struct packed {
        logic [CpWidth-1:0] code_point;
        logic [1:0]         status;
    } decoded_t;

    decoded_t            decoded_q[$];
    logic [RemWidth-1:0] cont_left;
    logic [CpWidth-1:0]  payload_acc;
    int unsigned         errors   = 0;
    int unsigned         checked  = 0;
    int unsigned         non_char = 0;

    // Count each mismatch and print a line for the first 50; keep the log short on a bad build
    task automatic report_mismatch(input string what, input logic [CpWidth-1:0] got,
                                   input logic [CpWidth-1:0] want);
        errors++;
        if (errors <= 50)
            $display("%0t ERROR %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Advance the decode state by one transfer; return 1 when a result is due
    function automatic logic decode_step(input logic [7:0] b, input logic eos,
                                         output decoded_t res);
        res = '0;
        if (cont_left == '0) begin
            if (eos) begin
                res.status = ST_END;
                return 1'b1;
            end
            if (b <= LEAD_ASCII_MAX) begin
                res.code_point = CpWidth'(b);
                res.status     = ST_CHAR;
                return 1'b1;
            end
            // Classify the lead byte: keep its payload bits, arm the continuation count; an invalid lead is bad
            if (b <= LEAD_2B_MAX) begin
                payload_acc = CpWidth'(b & 8'h1F);
                cont_left   = 3'd1;
            end else if (b <= LEAD_3B_MAX) begin
                payload_acc = CpWidth'(b & 8'h0F);
                cont_left   = 3'd2;
            end else if (b <= LEAD_4B_MAX) begin
                payload_acc = CpWidth'(b & 8'h07);
                cont_left   = 3'd3;
            end else if (b <= LEAD_5B_MAX) begin
                payload_acc = CpWidth'(b & 8'h03);
                cont_left   = 3'd4;
            end else if (b <= LEAD_6B_MAX) begin
                payload_acc = CpWidth'(b & 8'h01);
                cont_left   = 3'd5;
            end else begin
                payload_acc = '0;
                res.status  = ST_BAD;
                return 1'b1;
            end
            return 1'b0;
        end
        // Inside a sequence: end of stream truncates, a low byte is bad encoding
        if (eos || b < CONT_MIN) begin
            cont_left   = '0;
            payload_acc = '0;
            res.status  = eos ? ST_TRUNC : ST_BAD;
            return 1'b1;
        end
        payload_acc = {payload_acc[CpWidth-7:0], b[5:0]};
        cont_left   = cont_left - 3'd1;
        if (cont_left == '0) begin
            res.code_point = payload_acc;
            res.status     = ST_CHAR;
            payload_acc    = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge aclk) begin
        decoded_t want;
        if (!aresetn) begin
            cont_left   = '0;
            payload_acc = '0;
            decoded_q.delete();
        end else begin
            // Predict from every accepted input transfer
            if (s_valid && s_ready) begin
                if (decode_step(s_data_byte, s_end_of_stream, want))
                    decoded_q.push_back(want);
            end
            // Compare every accepted result transfer against the oldest prediction
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("result transfer with nothing pending, status",
                                    CpWidth'(m_status), '0);
                end else begin
                    want = decoded_q.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", CpWidth'(m_status), CpWidth'(want.status));
                    if (m_code_point !== want.code_point)
                        report_mismatch("code point", m_code_point, want.code_point);
                    checked++;
                    if (want.status != ST_CHAR)
                        non_char++;
                end
            end
        end
        mismatch_count  <= errors;
        pending_results <= decoded_q.size();
        results_checked <= checked;
        status_results  <= non_char;
    end

endmodule

// ===== verif/utf8_byte_stream_decoder_tb.sv =====
`timescale 1ns / 100ps
// Top of the UTF-8 byte stream decoder testbench: clock, reset, byte stimulus
// and output back-pressure. Depends on u8bsd_pkg, the decoder and its checker.
module utf8_byte_stream_decoder_tb;
    import u8bsd_pkg::*;

    localparam int unsigned OutputHoldCycles = 300;
    localparam int unsigned TargetItems      = 950;

    logic               aclk            = 1'b0;
    logic               aresetn         = 1'b0;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic [7:0]         s_data_byte     = 8'h00;
    logic               s_end_of_stream = 1'b0;
    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic [CpWidth-1:0] m_code_point;
    logic [1:0]         m_status;

    logic               random_phase = 1'b0;
    logic               long_hold    = 1'b0;
    int unsigned        items_sent   = 0;
    int unsigned        mismatch_count;
    int unsigned        pending_results;
    int unsigned        results_checked;
    int unsigned        status_results;

    always #2 aclk = ~aclk;

    utf8_byte_stream_decoder dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_stream (s_end_of_stream),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_code_point    (m_code_point),
        .m_status        (m_status)
    );

    utf8_byte_stream_decoder_checker scoreboard (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_stream (s_end_of_stream),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_code_point    (m_code_point),
        .m_status        (m_status),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .status_results  (status_results)
    );

    // Idle length: mostly none, often short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Lead byte of the class that opens a sequence of seq_len bytes
    function automatic logic [7:0] lead_byte(input int unsigned seq_len);
        case (seq_len)
            1: return 8'($urandom_range(0, LEAD_ASCII_MAX));
            2: return 8'($urandom_range(CONT_MIN, LEAD_2B_MAX));
            3: return 8'($urandom_range(LEAD_2B_MAX + 1, LEAD_3B_MAX));
            4: return 8'($urandom_range(LEAD_3B_MAX + 1, LEAD_4B_MAX));
            5: return 8'($urandom_range(LEAD_4B_MAX + 1, LEAD_5B_MAX));
            default: return 8'($urandom_range(LEAD_5B_MAX + 1, LEAD_6B_MAX));
        endcase
    endfunction

    // Continuation byte; the top two bits are ignored, so sometimes use 0xC0-0xFF
    function automatic logic [7:0] cont_byte();
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(8'hC0, 8'hFF));
        return {2'b10, 6'($urandom)};
    endfunction

    // Offer one transfer after a random gap and hold it until accepted
    task automatic send_item(input logic [7:0] b, input logic eos);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_data_byte     <= b;
        s_end_of_stream <= eos;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Receiver: random stalls and bursts, and one long hold to fill the block
    initial begin
        int unsigned stall_left;
        int unsigned burst_left;
        stall_left = 0;
        burst_left = 0;
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                m_ready <= 1'b0;
            end else if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (burst_left != 0) begin
                m_ready <= 1'b1;
                burst_left--;
            end else begin
                m_ready    <= 1'b1;
                burst_left = $urandom_range(0, 40);
                stall_left = pick_gap();
            end
        end
    end

    // Long output hold, counted here while the sender keeps offering bytes
    initial begin
        wait (random_phase);
        repeat ($urandom_range(20, 100)) @(posedge aclk);
        long_hold <= 1'b1;
        repeat (OutputHoldCycles) @(posedge aclk);
        long_hold <= 1'b0;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int unsigned pick;
        int unsigned seq_len;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: ASCII extremes, end while idle, invalid leads, stray lead
        send_item(8'h00, 1'b0);
        send_item(8'h7F, 1'b0);
        send_item(8'hA5, 1'b1);
        send_item(8'hFE, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'hBF, 1'b0);
        // Largest two-byte, smallest four-byte, largest five-byte and largest six-byte code points
        send_item(8'hDF, 1'b0);
        send_item(8'hBF, 1'b0);
        send_item(8'hF0, 1'b0);
        repeat (3) send_item(8'h80, 1'b0);
        send_item(8'hFB, 1'b0);
        repeat (4) send_item(8'hBF, 1'b0);
        send_item(8'hFD, 1'b0);
        repeat (5) send_item(8'hBF, 1'b0);
        // Bad continuation byte, then end of stream inside a sequence
        send_item(8'hC2, 1'b0);
        send_item(8'h41, 1'b0);
        send_item(8'hE2, 1'b0);
        send_item(8'h82, 1'b0);
        send_item(8'h5A, 1'b1);

        // Random: mostly well-formed sequences, the rest broken ones and noise
        random_phase = 1'b1;
        while (items_sent < TargetItems) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                seq_len = $urandom_range(1, 6);
                send_item(lead_byte(seq_len), 1'b0);
                repeat (seq_len - 1) send_item(cont_byte(), 1'b0);
            end else if (pick < 85) begin
                // Cut a sequence short by end of stream or by a low byte
                seq_len = $urandom_range(2, 6);
                send_item(lead_byte(seq_len), 1'b0);
                repeat ($urandom_range(0, seq_len - 2)) send_item(cont_byte(), 1'b0);
                if (pick < 75)
                    send_item(8'($urandom), 1'b1);
                else
                    send_item(8'($urandom_range(0, CONT_MIN - 1)), 1'b0);
            end else if (pick < 90) begin
                send_item(8'hFE | 8'($urandom_range(0, 1)), 1'b0);
            end else if (pick < 95) begin
                send_item(8'($urandom), 1'b1);
            end else begin
                send_item(8'($urandom), 1'($urandom_range(0, 1)));
            end
        end
        s_valid <= 1'b0;

        // Drain outstanding results, then keep the clock running for any strays
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Run covered %0d input transfers and %0d checked results (%0d end or error)",
                 items_sent, results_checked, status_results);
        $display("with random gaps on both channels and one %0d-cycle output hold.",
                 OutputHoldCycles);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
